// ===== rtl/core/efg_pkg.sv =====
// efg_pkg: shared types and constants for the event flag group
// holds command and status codes, item and result structs, waiter slot entry
// no dependencies
package efg_pkg;

  localparam int WaitSlots = 8;
  localparam int FlagWidth = 32;
  localparam int IdWidth   = 8;
  localparam int SlotIdxW  = $clog2(WaitSlots);
  localparam int CntW      = $clog2(WaitSlots + 1);

  typedef enum logic [2:0] {
    CMD_WAIT  = 3'd0,
    CMD_TRY   = 3'd1,
    CMD_SET   = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_QUERY = 3'd4,
    CMD_FLUSH = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_UNAVAIL = 3'd1,
    ST_QUEUED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_WOKEN   = 3'd4,
    ST_DELETED = 3'd5,
    ST_DONE    = 3'd6
  } status_e;

  // mode bits of a waiter
  typedef struct packed {
    logic consume;
    logic want_all;
    logic want_set;
  } mode_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [IdWidth-1:0]   waiter_id;
    logic                 want_set;
    logic                 want_all;
    logic                 consume;
    logic [FlagWidth-1:0] request_mask;
    logic [FlagWidth-1:0] change_mask;
  } item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [IdWidth-1:0]   task_id;
    logic [FlagWidth-1:0] matched_flags;
    logic [FlagWidth-1:0] flag_value;
    logic [3:0]           waiter_count;
    logic                 last;
  } result_t;

  // one queued waiter
  typedef struct packed {
    logic [IdWidth-1:0]   task_id;
    mode_t                mode;
    logic [FlagWidth-1:0] request;
  } slot_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== rtl/core/event_flag_group_with_waiters_top.sv =====
// event_flag_group_with_waiters_top: event flag group with an ordered waiter queue
// instantiates efg_cell (queue chain) and efg_eval (condition unit)
// depends on efg_pkg
//
// An item is taken when start is high and busy low. Wait, try, query and set,
// clear or flush with no waiters answer with one result on the next cycle.
// A set or clear with n queued waiters walks the queue one waiter a cycle
// through the single condition unit, then puts out one result per woken
// waiter on consecutive cycles, or one done result if none wakes. A flush
// with n waiters gives n results on consecutive cycles. Results carry a
// strobe for one cycle and cannot be held off; last marks the final result
// of an item.
module event_flag_group_with_waiters_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  efg_pkg::item_t    item,
  output logic              busy,
  output logic              strobe,
  output efg_pkg::result_t  result
);

  localparam int NS = efg_pkg::WaitSlots;

  typedef enum logic [1:0] {IDLE, WALK, EMIT, FLUSH} state_t;

  state_t                          state;
  logic [efg_pkg::FlagWidth-1:0]   flag_word;
  logic [efg_pkg::CntW-1:0]        cnt;
  logic [efg_pkg::CntW-1:0]        remain;
  logic [efg_pkg::CntW-1:0]        kept;
  logic [efg_pkg::CntW-1:0]        nwoke;
  logic [efg_pkg::IdWidth-1:0]     wk_task [NS];
  logic [efg_pkg::FlagWidth-1:0]   wk_calc [NS];

  efg_pkg::slot_t                  cell_q [NS];
  efg_pkg::slot_t                  new_entry;
  efg_pkg::cell_ctl_t              cell_ctl [NS];
  logic                            shift_en;
  logic                            load_en;
  logic [efg_pkg::SlotIdxW-1:0]    load_idx;

  logic [efg_pkg::FlagWidth-1:0]   ev_flags;
  efg_pkg::mode_t                  ev_mode;
  logic [efg_pkg::FlagWidth-1:0]   ev_req;
  logic                            ev_ok;
  logic [efg_pkg::FlagWidth-1:0]   ev_calc;
  logic [efg_pkg::FlagWidth-1:0]   ev_flags_next;

  logic                            accept;
  logic [efg_pkg::FlagWidth-1:0]   changed;
  logic [efg_pkg::CntW-1:0]        walk_pos;

  assign accept = start && (state == IDLE);
  assign busy   = (state != IDLE);

  // flag word after a set or clear
  assign changed = (item.cmd == efg_pkg::CMD_SET) ? (flag_word | item.change_mask)
                                                   : (flag_word & ~item.change_mask);

  // condition unit: new item when idle, queue head while walking
  always_comb begin
    if (state == IDLE) begin
      ev_mode = '{consume: item.consume, want_all: item.want_all, want_set: item.want_set};
      ev_req  = item.request_mask;
    end else begin
      ev_mode = cell_q[0].mode;
      ev_req  = cell_q[0].request;
    end
  end
  assign ev_flags = flag_word;

  efg_eval u_eval (
    .flags      (ev_flags),
    .mode       (ev_mode),
    .request    (ev_req),
    .ok         (ev_ok),
    .calc       (ev_calc),
    .flags_next (ev_flags_next)
  );

  // queue chain control
  assign walk_pos = remain - 1'b1 + kept;
  always_comb begin
    shift_en  = (state == WALK) || (state == FLUSH);
    load_en   = 1'b0;
    load_idx  = cnt[efg_pkg::SlotIdxW-1:0];
    new_entry = '{task_id: item.waiter_id, mode: ev_mode, request: item.request_mask};
    if (state == WALK) begin
      load_en   = !ev_ok;
      load_idx  = walk_pos[efg_pkg::SlotIdxW-1:0];
      new_entry = cell_q[0];
    end else if (accept && item.cmd == efg_pkg::CMD_WAIT && !ev_ok
                 && cnt < efg_pkg::CntW'(NS)) begin
      load_en = 1'b1;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cell
    efg_pkg::slot_t nb;
    if (i == NS - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    assign cell_ctl[i] = '{shift: shift_en,
                           load: load_en && (load_idx == efg_pkg::SlotIdxW'(i))};
    efg_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .neighbor   (nb),
      .load_entry (new_entry),
      .entry      (cell_q[i])
    );
  end

  // woken-waiter buffer, drained from the head
  always_ff @(posedge clk) begin
    if (state == WALK && ev_ok) begin
      wk_task[nwoke[efg_pkg::SlotIdxW-1:0]] <= cell_q[0].task_id;
      wk_calc[nwoke[efg_pkg::SlotIdxW-1:0]] <= ev_calc;
    end else if (state == EMIT) begin
      for (int i = 0; i < NS - 1; i++) begin
        wk_task[i] <= wk_task[i+1];
        wk_calc[i] <= wk_calc[i+1];
      end
    end
  end

  // sequencer, flag word, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      flag_word <= '0;
      cnt       <= '0;
      remain    <= '0;
      kept      <= '0;
      nwoke     <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            result.task_id       <= '0;
            result.matched_flags <= '0;
            result.flag_value    <= flag_word;
            result.waiter_count  <= cnt;
            result.last          <= 1'b1;
            result.status        <= efg_pkg::ST_DONE;
            unique case (item.cmd)
              efg_pkg::CMD_WAIT, efg_pkg::CMD_TRY: begin
                strobe               <= 1'b1;
                result.task_id       <= item.waiter_id;
                result.matched_flags <= ev_calc;
                result.flag_value    <= ev_flags_next;
                flag_word            <= ev_flags_next;
                if (ev_ok) begin
                  result.status <= efg_pkg::ST_GRANTED;
                end else if (item.cmd == efg_pkg::CMD_TRY) begin
                  result.status <= efg_pkg::ST_UNAVAIL;
                end else if (cnt == efg_pkg::CntW'(NS)) begin
                  result.status <= efg_pkg::ST_FULL;
                end else begin
                  result.status       <= efg_pkg::ST_QUEUED;
                  result.waiter_count <= cnt + 1'b1;
                  cnt                 <= cnt + 1'b1;
                end
              end
              efg_pkg::CMD_SET, efg_pkg::CMD_CLEAR: begin
                flag_word <= changed;
                if (cnt == '0) begin
                  strobe            <= 1'b1;
                  result.flag_value <= changed;
                end else begin
                  remain <= cnt;
                  kept   <= '0;
                  nwoke  <= '0;
                  state  <= WALK;
                end
              end
              efg_pkg::CMD_FLUSH: begin
                if (cnt == '0) begin
                  strobe <= 1'b1;
                end else begin
                  remain <= cnt;
                  cnt    <= '0;
                  state  <= FLUSH;
                end
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end
        WALK: begin
          logic [efg_pkg::CntW-1:0] kept_n;
          logic [efg_pkg::CntW-1:0] woke_n;
          kept_n = ev_ok ? kept : kept + 1'b1;
          woke_n = ev_ok ? nwoke + 1'b1 : nwoke;
          flag_word <= ev_flags_next;
          kept      <= kept_n;
          nwoke     <= woke_n;
          remain    <= remain - 1'b1;
          if (remain == efg_pkg::CntW'(1)) begin
            cnt <= kept_n;
            if (woke_n == '0) begin
              strobe               <= 1'b1;
              result.status        <= efg_pkg::ST_DONE;
              result.task_id       <= '0;
              result.matched_flags <= '0;
              result.flag_value    <= ev_flags_next;
              result.waiter_count  <= kept_n;
              result.last          <= 1'b1;
              state                <= IDLE;
            end else begin
              state <= EMIT;
            end
          end
        end
        EMIT: begin
          strobe               <= 1'b1;
          result.status        <= efg_pkg::ST_WOKEN;
          result.task_id       <= wk_task[0];
          result.matched_flags <= wk_calc[0];
          result.flag_value    <= flag_word;
          result.waiter_count  <= cnt;
          result.last          <= (nwoke == efg_pkg::CntW'(1));
          nwoke                <= nwoke - 1'b1;
          if (nwoke == efg_pkg::CntW'(1)) begin
            state <= IDLE;
          end
        end
        FLUSH: begin
          strobe               <= 1'b1;
          result.status        <= efg_pkg::ST_DELETED;
          result.task_id       <= cell_q[0].task_id;
          result.matched_flags <= '0;
          result.flag_value    <= flag_word;
          result.waiter_count  <= '0;
          result.last          <= (remain == efg_pkg::CntW'(1));
          remain               <= remain - 1'b1;
          if (remain == efg_pkg::CntW'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // queue never holds more than its slots
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= efg_pkg::CntW'(NS)) else $error("waiter count out of range");

  // an accepted item answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (strobe || busy)) else $error("accepted item dropped");

  // results of one item come on consecutive cycles
  a_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> strobe) else $error("gap inside result burst");

  // no new item is taken while a burst is still open
  a_busy_in_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> busy) else $error("idle during result burst");
`endif

endmodule

// ===== rtl/core/efg_cell.sv =====
// efg_cell: one waiter slot of the queue chain
// takes its neighbor's entry on shift, or a new entry on load
// depends on efg_pkg
module efg_cell (
  input  logic              clk,
  input  efg_pkg::cell_ctl_t ctl,
  input  efg_pkg::slot_t    neighbor,
  input  efg_pkg::slot_t    load_entry,
  output efg_pkg::slot_t    entry
);

  efg_pkg::slot_t slot;

  // load wins over shift
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot <= load_entry;
    end else if (ctl.shift) begin
      slot <= neighbor;
    end
  end

  assign entry = slot;

endmodule

// ===== rtl/core/efg_eval.sv =====
// efg_eval: wait condition check and consume update
// shared by new waits and tries and by the queue walk
// depends on efg_pkg
module efg_eval (
  input  logic [efg_pkg::FlagWidth-1:0] flags,
  input  efg_pkg::mode_t                mode,
  input  logic [efg_pkg::FlagWidth-1:0] request,
  output logic                          ok,
  output logic [efg_pkg::FlagWidth-1:0] calc,
  output logic [efg_pkg::FlagWidth-1:0] flags_next
);

  // bits found in the wanted state
  assign calc = mode.want_set ? (flags & request) : (~flags & request);
  assign ok   = mode.want_all ? (calc == request) : (calc != '0);

  // consume drives the requested bits out of the wanted state on success
  always_comb begin
    flags_next = flags;
    if (ok && mode.consume) begin
      flags_next = mode.want_set ? (flags & ~request) : (flags | request);
    end
  end

endmodule
